// ===== rtl/mesh_vertex_dedup_indexer_assert.svh =====
// Assertion macros for the vertex dedup indexer.
`ifndef MESH_VERTEX_DEDUP_INDEXER_ASSERT_SVH
`define MESH_VERTEX_DEDUP_INDEXER_ASSERT_SVH

`ifndef SYNTHESIS
`define MVDI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mvdi assertion failed");
`define MVDI_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mvdi assertion failed");
`else
`define MVDI_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MVDI_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/mvdi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mvdi_pkg;

    localparam int ATTR_DEPTH   = 1024;
    localparam int VERTEX_DEPTH = 1024;
    localparam int AIDX_W = (ATTR_DEPTH > 1) ? $clog2(ATTR_DEPTH) : 1;
    localparam int ACNT_W = $clog2(ATTR_DEPTH + 1);
    localparam int VIDX_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int VCNT_W = $clog2(VERTEX_DEPTH + 1);
    localparam int REF_W  = 12;
    localparam int RES_W  = ((ACNT_W > REF_W) ? ACNT_W : REF_W) + 1;
    localparam int NCELL  = 8;
    localparam int WORD_W = 32;
    localparam int DRAIN_W = $clog2(2 * NCELL + 1);

    typedef enum logic [1:0] {
        OP_LOAD_POINT  = 2'd0,
        OP_LOAD_NORMAL = 2'd1,
        OP_LOAD_UV     = 2'd2,
        OP_FACE        = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_REF   = 2'd1,
        ST_VTX_FULL  = 2'd2,
        ST_ATTR_FULL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESOLVE,
        S_FETCH,
        S_SEARCH,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [31:0]             coord_x;
        logic [31:0]             coord_y;
        logic [31:0]             coord_z;
        logic signed [REF_W-1:0] point_ref;
        logic signed [REF_W-1:0] normal_ref;
        logic signed [REF_W-1:0] texcoord_ref;
    } in_t;

    typedef struct packed {
        logic [9:0] vertex_index;
        logic       is_new;
        logic [1:0] status;
    } out_t;

    typedef struct packed {
        logic              valid;
        logic [VIDX_W-1:0] addr;
        logic              match;
    } token_t;

    typedef struct packed {
        logic              en;
        logic [VIDX_W-1:0] addr;
    } wr_t;

    typedef struct packed {
        logic              ok;
        logic [AIDX_W-1:0] slot;
    } res_t;

    function automatic res_t resolve(logic signed [REF_W-1:0] r, logic [ACNT_W-1:0] cnt);
        res_t       res;
        logic [RES_W-1:0] rs;
        logic [RES_W-1:0] c;
        logic [RES_W-1:0] mag;
        rs  = {{(RES_W - REF_W){r[REF_W-1]}}, r};
        c   = {{(RES_W - ACNT_W){1'b0}}, cnt};
        mag = '0 - rs;
        res.ok   = 1'b0;
        res.slot = '0;
        if (rs == '0) begin
            res.ok = 1'b0;
        end else if (rs[RES_W-1]) begin
            res.ok   = !(mag > c);
            res.slot = AIDX_W'(c - mag);
        end else begin
            res.ok   = !(rs > c);
            res.slot = AIDX_W'(rs - RES_W'(1));
        end
        return res;
    endfunction

    function automatic logic [9:0] to_index(logic [VCNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[9:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mesh_vertex_dedup_indexer.sv =====
// Vertex dedup indexer: load requests append points, normals or texture
// coordinates to their stores, or report the store full, and answer in
// the accept cycle's next cycle. A face-corner request resolves its
// three OBJ references, fetches the attributes, then scans the vertex
// table through a row of eight compare cells, one 32-bit word lane each,
// one entry issued per cycle. A corner's answer waits on the linear scan,
// on the cell pipeline and on a free result side; a bad reference skips
// the fetch and the scan. One request is worked on at a time, and a new
// request is taken only once the previous result has left or leaves in
// that same cycle.
`timescale 1ns / 1ps
`default_nettype none
module mesh_vertex_dedup_indexer (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire mvdi_pkg::in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output mvdi_pkg::out_t     m_data
);
    localparam int NC = mvdi_pkg::NCELL;
    localparam int WW = mvdi_pkg::WORD_W;

    logic [3*WW-1:0] pos_mem [mvdi_pkg::ATTR_DEPTH];
    logic [3*WW-1:0] nrm_mem [mvdi_pkg::ATTR_DEPTH];
    logic [2*WW-1:0] uv_mem  [mvdi_pkg::ATTR_DEPTH];
    logic [3*WW-1:0] pos_rd_reg;
    logic [3*WW-1:0] nrm_rd_reg;
    logic [2*WW-1:0] uv_rd_reg;

    mvdi_pkg::state_t state_reg, state_next;
    mvdi_pkg::in_t    item_reg;
    mvdi_pkg::out_t   out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic [mvdi_pkg::ACNT_W-1:0] pcnt_reg, pcnt_next;
    logic [mvdi_pkg::ACNT_W-1:0] ncnt_reg, ncnt_next;
    logic [mvdi_pkg::ACNT_W-1:0] ucnt_reg, ucnt_next;
    logic [mvdi_pkg::VCNT_W-1:0] vcnt_reg, vcnt_next;
    logic [mvdi_pkg::VCNT_W-1:0] scan_reg, scan_next;
    logic [mvdi_pkg::DRAIN_W-1:0] drain_reg, drain_next;
    logic [NC*WW-1:0]  key_reg, key_next;
    logic              hit_reg, hit_next;
    logic [mvdi_pkg::VIDX_W-1:0] hit_idx_reg, hit_idx_next;

    mvdi_pkg::res_t   pres, nres, ures;
    logic             bad_ref;
    logic             accept;
    logic             out_free;
    logic             issue;
    logic             vtx_full;
    logic             pos_we, nrm_we, uv_we;
    mvdi_pkg::token_t tok [NC+1];
    mvdi_pkg::wr_t    vwr;

    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign issue    = (state_reg == mvdi_pkg::S_SEARCH) && (scan_reg < vcnt_reg);
    assign vtx_full = vcnt_reg >= mvdi_pkg::VCNT_W'(mvdi_pkg::VERTEX_DEPTH);

    always_comb begin
        pres = mvdi_pkg::resolve(item_reg.point_ref, pcnt_reg);
        nres = mvdi_pkg::resolve(item_reg.normal_ref, ncnt_reg);
        ures = mvdi_pkg::resolve(item_reg.texcoord_ref, ucnt_reg);
        bad_ref = ((pcnt_reg != '0) && !pres.ok) || ((ncnt_reg != '0) && !nres.ok)
            || ((ucnt_reg != '0) && !ures.ok);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mvdi_pkg::S_IDLE: begin
                if (accept && (s_data.opcode == mvdi_pkg::OP_FACE)) begin
                    state_next = mvdi_pkg::S_RESOLVE;
                end
            end
            mvdi_pkg::S_RESOLVE: begin
                state_next = bad_ref ? mvdi_pkg::S_DONE : mvdi_pkg::S_FETCH;
            end
            mvdi_pkg::S_FETCH:  state_next = mvdi_pkg::S_SEARCH;
            mvdi_pkg::S_SEARCH: begin
                if (!issue) begin
                    state_next = mvdi_pkg::S_DRAIN;
                end
            end
            mvdi_pkg::S_DRAIN: begin
                if (drain_reg == mvdi_pkg::DRAIN_W'(2 * NC)) begin
                    state_next = mvdi_pkg::S_DONE;
                end
            end
            mvdi_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = mvdi_pkg::S_IDLE;
                end
            end
            default: state_next = mvdi_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == mvdi_pkg::S_IDLE) && out_free;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        pcnt_next      = pcnt_reg;
        ncnt_next      = ncnt_reg;
        ucnt_next      = ucnt_reg;
        vcnt_next      = vcnt_reg;
        scan_next      = scan_reg;
        drain_next     = drain_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        pos_we         = 1'b0;
        nrm_we         = 1'b0;
        uv_we          = 1'b0;
        vwr            = '0;
        vwr.addr       = vcnt_reg[mvdi_pkg::VIDX_W-1:0];
        tok[0].valid   = issue;
        tok[0].addr    = scan_reg[mvdi_pkg::VIDX_W-1:0];
        tok[0].match   = 1'b1;
        case (state_reg)
            mvdi_pkg::S_IDLE: begin
                if (accept && (s_data.opcode != mvdi_pkg::OP_FACE)) begin
                    out_valid_next      = 1'b1;
                    out_next            = '0;
                    out_next.status     = mvdi_pkg::ST_OK;
                    case (s_data.opcode)
                        mvdi_pkg::OP_LOAD_POINT: begin
                            if (pcnt_reg >= mvdi_pkg::ACNT_W'(mvdi_pkg::ATTR_DEPTH)) begin
                                out_next.status = mvdi_pkg::ST_ATTR_FULL;
                            end else begin
                                pos_we    = 1'b1;
                                pcnt_next = pcnt_reg + 1'b1;
                            end
                        end
                        mvdi_pkg::OP_LOAD_NORMAL: begin
                            if (ncnt_reg >= mvdi_pkg::ACNT_W'(mvdi_pkg::ATTR_DEPTH)) begin
                                out_next.status = mvdi_pkg::ST_ATTR_FULL;
                            end else begin
                                nrm_we    = 1'b1;
                                ncnt_next = ncnt_reg + 1'b1;
                            end
                        end
                        default: begin
                            if (ucnt_reg >= mvdi_pkg::ACNT_W'(mvdi_pkg::ATTR_DEPTH)) begin
                                out_next.status = mvdi_pkg::ST_ATTR_FULL;
                            end else begin
                                uv_we     = 1'b1;
                                ucnt_next = ucnt_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            mvdi_pkg::S_RESOLVE: begin
                hit_next = 1'b0;
                if (bad_ref) begin
                    hit_next = 1'b1;
                end
            end
            mvdi_pkg::S_FETCH: begin
                key_next  = '0;
                scan_next = '0;
                hit_next  = 1'b0;
                if (pcnt_reg != '0) begin
                    key_next[3*WW-1:0] = pos_rd_reg;
                end
                if (ncnt_reg != '0) begin
                    key_next[6*WW-1:3*WW] = nrm_rd_reg;
                end
                if (ucnt_reg != '0) begin
                    key_next[8*WW-1:6*WW] = uv_rd_reg;
                end
            end
            mvdi_pkg::S_SEARCH: begin
                drain_next = '0;
                if (issue) begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            mvdi_pkg::S_DRAIN: begin
                drain_next = drain_reg + 1'b1;
            end
            mvdi_pkg::S_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (bad_ref) begin
                        out_next.status = mvdi_pkg::ST_BAD_REF;
                    end else if (hit_reg) begin
                        out_next.vertex_index = mvdi_pkg::to_index(
                            mvdi_pkg::VCNT_W'(hit_idx_reg));
                        out_next.status = mvdi_pkg::ST_OK;
                    end else if (vtx_full) begin
                        out_next.status = mvdi_pkg::ST_VTX_FULL;
                    end else begin
                        out_next.vertex_index = mvdi_pkg::to_index(vcnt_reg);
                        out_next.is_new       = 1'b1;
                        out_next.status       = mvdi_pkg::ST_OK;
                        vwr.en                = 1'b1;
                        vcnt_next             = vcnt_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if ((state_reg == mvdi_pkg::S_SEARCH || state_reg == mvdi_pkg::S_DRAIN)
            && tok[NC].valid && tok[NC].match && !hit_reg) begin
            hit_next     = 1'b1;
            hit_idx_next = tok[NC].addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pcnt_reg[mvdi_pkg::AIDX_W-1:0]] <=
                {s_data.coord_z, s_data.coord_y, s_data.coord_x};
        end
        if (nrm_we) begin
            nrm_mem[ncnt_reg[mvdi_pkg::AIDX_W-1:0]] <=
                {s_data.coord_z, s_data.coord_y, s_data.coord_x};
        end
        if (uv_we) begin
            uv_mem[ucnt_reg[mvdi_pkg::AIDX_W-1:0]] <= {s_data.coord_y, s_data.coord_x};
        end
        pos_rd_reg <= pos_mem[pres.slot];
        nrm_rd_reg <= nrm_mem[nres.slot];
        uv_rd_reg  <= uv_mem[ures.slot];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        out_reg     <= out_next;
        key_reg     <= key_next;
        scan_reg    <= scan_next;
        drain_reg   <= drain_next;
        hit_idx_reg <= hit_idx_next;
        if (!aresetn) begin
            state_reg     <= mvdi_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            pcnt_reg      <= '0;
            ncnt_reg      <= '0;
            ucnt_reg      <= '0;
            vcnt_reg      <= '0;
            hit_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pcnt_reg      <= pcnt_next;
            ncnt_reg      <= ncnt_next;
            ucnt_reg      <= ucnt_next;
            vcnt_reg      <= vcnt_next;
            hit_reg       <= hit_next;
        end
    end

    for (genvar k = 0; k < NC; k++) begin : g_cell
        mvdi_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .tok_in   (tok[k]),
            .key_word (key_reg[k*WW +: WW]),
            .wr       (vwr),
            .wr_word  (key_reg[k*WW +: WW]),
            .tok_out  (tok[k+1])
        );
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`include "mesh_vertex_dedup_indexer_assert.svh"

    `MVDI_ASSERT_IMP(a_scan_bound, aclk, aresetn, state_reg == mvdi_pkg::S_SEARCH, scan_reg <= vcnt_reg)
    `MVDI_ASSERT_IMP(a_new_ok, aclk, aresetn, m_valid && m_data.is_new, m_data.status == mvdi_pkg::ST_OK)
    `MVDI_ASSERT_NXT(a_append_step, aclk, aresetn, vwr.en, vcnt_reg == $past(vcnt_reg) + 1'b1)
endmodule
`default_nettype wire

// ===== rtl/mvdi_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mvdi_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire mvdi_pkg::token_t            tok_in,
    input  wire logic [mvdi_pkg::WORD_W-1:0] key_word,
    input  wire mvdi_pkg::wr_t               wr,
    input  wire logic [mvdi_pkg::WORD_W-1:0] wr_word,
    output mvdi_pkg::token_t                 tok_out
);
    logic [mvdi_pkg::WORD_W-1:0] lane_mem [mvdi_pkg::VERTEX_DEPTH];
    logic [mvdi_pkg::WORD_W-1:0] rd_reg;
    mvdi_pkg::token_t            tok_a_reg;
    mvdi_pkg::token_t            tok_b_reg;
    mvdi_pkg::token_t            tok_b_next;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            lane_mem[wr.addr] <= wr_word;
        end
        rd_reg <= lane_mem[tok_in.addr];
    end

    always_comb begin
        tok_b_next       = tok_a_reg;
        tok_b_next.match = tok_a_reg.match && (rd_reg == key_word);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_a_reg <= '0;
            tok_b_reg <= '0;
        end else begin
            tok_a_reg <= tok_in;
            tok_b_reg <= tok_b_next;
        end
    end

    assign tok_out = tok_b_reg;
endmodule
`default_nettype wire

// ===== tb/mesh_vertex_dedup_indexer_tb.sv =====
`timescale 1ns / 1ps

class vertex_scoreboard;
    logic [95:0]    points [mvdi_pkg::ATTR_DEPTH];
    logic [95:0]    normals [mvdi_pkg::ATTR_DEPTH];
    logic [63:0]    uvs [mvdi_pkg::ATTR_DEPTH];
    logic [255:0]   vertices [mvdi_pkg::VERTEX_DEPTH];
    int             point_cnt;
    int             normal_cnt;
    int             uv_cnt;
    int             vertex_cnt;
    mvdi_pkg::out_t pending[$];
    int             errors;

    function new();
        point_cnt = 0;
        normal_cnt = 0;
        uv_cnt = 0;
        vertex_cnt = 0;
        errors = 0;
    endfunction

    function bit lookup(logic signed [11:0] r, int cnt, output int slot);
        int v;
        v = r;
        slot = 0;
        if (v == 0) return 0;
        if (v < 0) begin
            if (-v > cnt) return 0;
            slot = cnt + v;
        end else begin
            if (v > cnt) return 0;
            slot = v - 1;
        end
        return 1;
    endfunction

    function void note_request(mvdi_pkg::in_t it);
        mvdi_pkg::out_t e;
        logic [255:0]   vx;
        int             slot;
        bit             bad;
        bit             hit;
        e = '0;
        vx = '0;
        bad = 0;
        hit = 0;
        case (mvdi_pkg::opcode_t'(it.opcode))
            mvdi_pkg::OP_LOAD_POINT: begin
                if (point_cnt >= mvdi_pkg::ATTR_DEPTH) begin
                    e.status = mvdi_pkg::ST_ATTR_FULL;
                end else begin
                    points[point_cnt] = {it.coord_x, it.coord_y, it.coord_z};
                    point_cnt++;
                end
            end
            mvdi_pkg::OP_LOAD_NORMAL: begin
                if (normal_cnt >= mvdi_pkg::ATTR_DEPTH) begin
                    e.status = mvdi_pkg::ST_ATTR_FULL;
                end else begin
                    normals[normal_cnt] = {it.coord_x, it.coord_y, it.coord_z};
                    normal_cnt++;
                end
            end
            mvdi_pkg::OP_LOAD_UV: begin
                if (uv_cnt >= mvdi_pkg::ATTR_DEPTH) begin
                    e.status = mvdi_pkg::ST_ATTR_FULL;
                end else begin
                    uvs[uv_cnt] = {it.coord_x, it.coord_y};
                    uv_cnt++;
                end
            end
            default: begin
                if (point_cnt > 0) begin
                    if (!lookup(it.point_ref, point_cnt, slot)) bad = 1;
                    else vx[255:160] = points[slot];
                end
                if (!bad && normal_cnt > 0) begin
                    if (!lookup(it.normal_ref, normal_cnt, slot)) bad = 1;
                    else vx[159:64] = normals[slot];
                end
                if (!bad && uv_cnt > 0) begin
                    if (!lookup(it.texcoord_ref, uv_cnt, slot)) bad = 1;
                    else vx[63:0] = uvs[slot];
                end
                if (bad) begin
                    e.status = mvdi_pkg::ST_BAD_REF;
                end else begin
                    for (int i = 0; i < vertex_cnt && !hit; i++) begin
                        if (vertices[i] === vx) begin
                            hit = 1;
                            e.vertex_index = i[9:0];
                        end
                    end
                    if (!hit) begin
                        if (vertex_cnt >= mvdi_pkg::VERTEX_DEPTH) begin
                            e.status = mvdi_pkg::ST_VTX_FULL;
                        end else begin
                            vertices[vertex_cnt] = vx;
                            e.vertex_index = vertex_cnt[9:0];
                            e.is_new = 1'b1;
                            vertex_cnt++;
                        end
                    end
                end
            end
        endcase
        pending = {pending, e};
    endfunction

    function void check_result(mvdi_pkg::out_t got);
        mvdi_pkg::out_t e;
        if (pending.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.vertex_index !== e.vertex_index) begin
            $error("vertex_index expected %0d actual %0d", e.vertex_index, got.vertex_index);
            errors++;
        end
        if (got.is_new !== e.is_new) begin
            $error("is_new expected %0d actual %0d", e.is_new, got.is_new);
            errors++;
        end
        if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status);
            errors++;
        end
    endfunction
endclass

module mesh_vertex_dedup_indexer_tb;
    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    mvdi_pkg::in_t  s_data;
    logic           m_valid;
    logic           m_ready;
    mvdi_pkg::out_t m_data;
    bit             calm;

    vertex_scoreboard sb;

    mesh_vertex_dedup_indexer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < 34);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        m_ready <= !idle_roll();
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h3f80_0000;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] pick_ref(int cnt);
        int v;
        if (cnt > 0 && $urandom_range(0, 99) < 80) begin
            v = $urandom_range(1, cnt);
            if ($urandom_range(0, 1)) v = -v;
            return v[11:0];
        end
        case ($urandom_range(0, 3))
            0: return 12'd0;
            1: begin v = cnt + 1; return v[11:0]; end
            2: begin v = -(cnt + 1); return v[11:0]; end
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic mvdi_pkg::in_t make_load(mvdi_pkg::opcode_t op);
        mvdi_pkg::in_t it;
        it.opcode = op;
        it.coord_x = pick_coord();
        it.coord_y = pick_coord();
        it.coord_z = pick_coord();
        it.point_ref = 12'($urandom);
        it.normal_ref = 12'($urandom);
        it.texcoord_ref = 12'($urandom);
        return it;
    endfunction

    function automatic mvdi_pkg::in_t make_corner();
        mvdi_pkg::in_t it;
        it = make_load(mvdi_pkg::OP_FACE);
        it.point_ref = pick_ref(sb.point_cnt);
        it.normal_ref = pick_ref(sb.normal_cnt);
        it.texcoord_ref = pick_ref(sb.uv_cnt);
        return it;
    endfunction

    function automatic mvdi_pkg::in_t corner(int p, int n, int t);
        mvdi_pkg::in_t it;
        it = make_load(mvdi_pkg::OP_FACE);
        it.point_ref = p[11:0];
        it.normal_ref = n[11:0];
        it.texcoord_ref = t[11:0];
        return it;
    endfunction

    function automatic mvdi_pkg::in_t load(mvdi_pkg::opcode_t op, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z);
        mvdi_pkg::in_t it;
        it = make_load(op);
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        return it;
    endfunction

    task automatic send_request(mvdi_pkg::in_t it);
        while (idle_roll()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(it);
    endtask

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int guard;
        sb = new();
        calm = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(corner(0, 0, 0));
        send_request(corner(5, -3, 2047));
        send_request(load(mvdi_pkg::OP_LOAD_POINT, 32'h0, 32'h0, 32'h0));
        send_request(load(mvdi_pkg::OP_LOAD_POINT, 32'hffff_ffff, 32'hffff_ffff,
                          32'hffff_ffff));
        send_request(load(mvdi_pkg::OP_LOAD_NORMAL, 32'h3f80_0000, 32'h0, 32'h8000_0000));
        send_request(load(mvdi_pkg::OP_LOAD_UV, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
        send_request(corner(0, 1, 1));
        send_request(corner(3, 1, 1));
        send_request(corner(-3, 1, 1));
        send_request(corner(1, 1, 1));
        send_request(corner(-2, -1, -1));
        send_request(corner(-1, 1, 1));
        send_request(corner(2, 1, -2048));
        send_request(corner(1, 1, 2047));
        send_request(corner(1, -1024, 1));
        send_request(corner(1024, 1, 1));
        send_request(corner(2, 0, 1));
        send_request(corner(2, -1, 1));

        for (int k = 0; k < 550; k++) begin
            calm = (k >= 200 && k < 300);
            if ($urandom_range(0, 99) < 40)
                send_request(make_load(mvdi_pkg::opcode_t'($urandom_range(0, 2))));
            else
                send_request(make_corner());
        end
        calm = 0;

        for (int k = 0; k < 12; k++) send_request(make_corner());
        s_valid <= 1'b0;

        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (2000) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
